@@ sv/imf3d_pkg.sv @@
// ----------------------------------------------------------------------------
// imf3d_pkg
// Shared constants, types and helpers of the 3D Metropolis spin-flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

package imf3d_pkg;

  localparam int unsigned MAX_EDGE    = 32;
  localparam int unsigned EDGE_W      = $clog2(MAX_EDGE);
  localparam int unsigned ROWS        = MAX_EDGE * MAX_EDGE;
  localparam int unsigned ROW_AW      = 2 * EDGE_W;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned TAB_ENTRIES = 16;
  localparam int unsigned TAB_REGS    = 4;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned NSUM_W      = 4;
  localparam int unsigned STEP_W      = 3;

  typedef logic [EDGE_W-1:0]   coord_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [MAX_EDGE-1:0] row_t;
  typedef logic [ROW_AW-1:0]   raddr_t;
  typedef logic [STEP_W-1:0]   step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X  = 3'd0,
    CFG_SIZE_Y  = 3'd1,
    CFG_SIZE_Z  = 3'd2,
    CFG_TABLE_0 = 3'd3,
    CFG_TABLE_1 = 3'd4,
    CFG_TABLE_2 = 3'd5,
    CFG_TABLE_3 = 3'd6
  } cfg_idx_e;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRIAL = 1'b1;

  // program steps
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_RD_ROW = 3'd1;
  localparam step_t STEP_RD_YM  = 3'd2;
  localparam step_t STEP_RD_YP  = 3'd3;
  localparam step_t STEP_RD_ZM  = 3'd4;
  localparam step_t STEP_RD_ZP  = 3'd5;
  localparam step_t STEP_CAP_ZP = 3'd6;
  localparam step_t STEP_COMMIT = 3'd7;

  typedef enum logic [2:0] {
    RD_HERE = 3'd0,
    RD_YM   = 3'd1,
    RD_YP   = 3'd2,
    RD_ZM   = 3'd3,
    RD_ZP   = 3'd4
  } rd_sel_e;

  typedef enum logic [2:0] {
    CAP_NONE = 3'd0,
    CAP_ROW  = 3'd1,
    CAP_YM   = 3'd2,
    CAP_YP   = 3'd3,
    CAP_ZM   = 3'd4,
    CAP_ZP   = 3'd5
  } cap_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_NO_REQ   = 2'd1,
    COND_OOR      = 2'd2,
    COND_OUT_FULL = 2'd3
  } cond_e;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_e rd_sel;
    cap_e    cap;
    logic    commit;
    cond_e   cond;
    step_t   target;
  } ctl_t;

  typedef struct packed {
    logic req_fire;
    logic oor;
    logic out_full;
  } stat_t;

  typedef struct packed {
    size_t nx;
    size_t ny;
    size_t nz;
    logic [TAB_ENTRIES-1:0][THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic busy;
  } clr_t;

  typedef struct packed {
    logic   en;
    raddr_t addr;
  } ram_rd_t;

  typedef struct packed {
    logic   en;
    raddr_t addr;
    row_t   data;
  } ram_wr_t;

  function automatic size_t eff_size(size_t s);
    size_t r;
    r = s;
    if (s < SIZE_W'(2)) begin
      r = SIZE_W'(2);
    end else if (s > SIZE_W'(MAX_EDGE)) begin
      r = SIZE_W'(MAX_EDGE);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/imf3d_if.sv @@
// ----------------------------------------------------------------------------
// imf3d_if
// Request and result channels of the spin-flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface imf3d_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [imf3d_pkg::EDGE_W-1:0] site_x;
  logic [imf3d_pkg::EDGE_W-1:0] site_y;
  logic [imf3d_pkg::EDGE_W-1:0] site_z;
  logic                         spin_in;
  logic [imf3d_pkg::THR_W-1:0]  random_value;

  modport source (
    output valid, command, site_x, site_y, site_z, spin_in, random_value,
    input  ready
  );
  modport sink (
    input  valid, command, site_x, site_y, site_z, spin_in, random_value,
    output ready
  );
endinterface

interface imf3d_res_if;
  logic                                valid;
  logic                                ready;
  logic                                flipped;
  logic                                spin_out;
  logic signed [imf3d_pkg::NSUM_W-1:0] neighbour_sum;
  logic [imf3d_pkg::CNT_W-1:0]         up_count;

  modport source (
    output valid, flipped, spin_out, neighbour_sum, up_count,
    input  ready
  );
  modport sink (
    input  valid, flipped, spin_out, neighbour_sum, up_count,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/imf3d_ram.sv @@
// ----------------------------------------------------------------------------
// imf3d_ram
// Lattice store, one row of x spins per word, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imf3d_ram (
  input  wire logic               clk_i,
  input  wire imf3d_pkg::ram_rd_t rd_i,
  input  wire imf3d_pkg::ram_wr_t wr_i,
  output imf3d_pkg::row_t         rd_data_o
);

  imf3d_pkg::row_t mem [imf3d_pkg::ROWS];
  imf3d_pkg::row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ sv/imf3d_seq.sv @@
// ----------------------------------------------------------------------------
// imf3d_seq
// Step counter and control store of the spin-flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

module imf3d_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire imf3d_pkg::stat_t stat_i,
  output imf3d_pkg::ctl_t       ctl_o
);

  imf3d_pkg::step_t pc_q, pc_d;
  imf3d_pkg::ctl_t  ctl;
  logic             jump;

  function automatic imf3d_pkg::ctl_t rom(imf3d_pkg::step_t s);
    imf3d_pkg::ctl_t c;
    c        = '0;
    c.rd_sel = imf3d_pkg::RD_HERE;
    c.cap    = imf3d_pkg::CAP_NONE;
    c.cond   = imf3d_pkg::COND_NEXT;
    c.target = imf3d_pkg::STEP_IDLE;
    case (s)
      imf3d_pkg::STEP_IDLE: begin
        c.take   = 1'b1;
        c.cond   = imf3d_pkg::COND_NO_REQ;
        c.target = imf3d_pkg::STEP_IDLE;
      end
      imf3d_pkg::STEP_RD_ROW: begin
        c.rd_en  = 1'b1;
        c.rd_sel = imf3d_pkg::RD_HERE;
        c.cond   = imf3d_pkg::COND_OOR;
        c.target = imf3d_pkg::STEP_COMMIT;
      end
      imf3d_pkg::STEP_RD_YM: begin
        c.rd_en  = 1'b1;
        c.rd_sel = imf3d_pkg::RD_YM;
        c.cap    = imf3d_pkg::CAP_ROW;
      end
      imf3d_pkg::STEP_RD_YP: begin
        c.rd_en  = 1'b1;
        c.rd_sel = imf3d_pkg::RD_YP;
        c.cap    = imf3d_pkg::CAP_YM;
      end
      imf3d_pkg::STEP_RD_ZM: begin
        c.rd_en  = 1'b1;
        c.rd_sel = imf3d_pkg::RD_ZM;
        c.cap    = imf3d_pkg::CAP_YP;
      end
      imf3d_pkg::STEP_RD_ZP: begin
        c.rd_en  = 1'b1;
        c.rd_sel = imf3d_pkg::RD_ZP;
        c.cap    = imf3d_pkg::CAP_ZM;
      end
      imf3d_pkg::STEP_CAP_ZP: begin
        c.cap = imf3d_pkg::CAP_ZP;
      end
      imf3d_pkg::STEP_COMMIT: begin
        // last step, counter wraps back to idle
        c.commit = 1'b1;
        c.cond   = imf3d_pkg::COND_OUT_FULL;
        c.target = imf3d_pkg::STEP_COMMIT;
      end
      default: begin
        c.cond   = imf3d_pkg::COND_NEXT;
      end
    endcase
    return c;
  endfunction

  assign ctl   = rom(pc_q);
  assign ctl_o = ctl;

  always_comb begin
    case (ctl.cond)
      imf3d_pkg::COND_NO_REQ:   jump = !stat_i.req_fire;
      imf3d_pkg::COND_OOR:      jump = stat_i.oor;
      imf3d_pkg::COND_OUT_FULL: jump = stat_i.out_full;
      default:                  jump = 1'b0;
    endcase
    pc_d = jump ? ctl.target : pc_q + imf3d_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= imf3d_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef ASSERT_OFF
  a_fire_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.req_fire |-> pc_q == imf3d_pkg::STEP_IDLE)
    else $error("request taken outside idle step");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == imf3d_pkg::STEP_IDLE && !stat_i.req_fire) |=> pc_q == imf3d_pkg::STEP_IDLE)
    else $error("sequencer left idle without a request");
`endif

endmodule

`default_nettype wire

@@ sv/imf3d_datapath.sv @@
// ----------------------------------------------------------------------------
// imf3d_datapath
// Request latch, neighbour gather, acceptance test, write-back and result.
// ----------------------------------------------------------------------------
`default_nettype none

module imf3d_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire imf3d_pkg::ctl_t  ctl_i,
  input  wire imf3d_pkg::cfg_t  cfg_i,
  input  wire imf3d_pkg::clr_t  clr_i,
  input  wire imf3d_pkg::row_t  rd_data_i,
  output imf3d_pkg::stat_t      stat_o,
  output imf3d_pkg::ram_rd_t    rd_o,
  output imf3d_pkg::ram_wr_t    wr_o,
  imf3d_req_if.sink             req,
  imf3d_res_if.source           res
);

  logic                        cmd_q;
  imf3d_pkg::coord_t           x_q, y_q, z_q;
  logic                        sin_q;
  logic [imf3d_pkg::THR_W-1:0] rnd_q;
  imf3d_pkg::row_t             row_q;
  logic                        ym_q, yp_q, zm_q, zp_q;
  logic [imf3d_pkg::CNT_W-1:0] up_total_q, up_total_d;

  logic                        res_valid_q;
  logic                        res_flipped_q;
  logic                        res_spin_q;
  logic signed [imf3d_pkg::NSUM_W-1:0] res_nsum_q;
  logic [imf3d_pkg::CNT_W-1:0] res_up_q;

  logic                        req_fire, in_range, out_full, commit_go;
  imf3d_pkg::coord_t           xm, xp, ym, yp, zm, zp;
  logic                        cur, flip, new_spin;
  logic [2:0]                  n_up;
  logic [imf3d_pkg::THR_W-1:0] thr;
  logic signed [imf3d_pkg::NSUM_W-1:0] nsum;
  imf3d_pkg::row_t             wr_row;

  function automatic imf3d_pkg::coord_t dec_wrap(imf3d_pkg::coord_t c, imf3d_pkg::size_t n);
    imf3d_pkg::size_t nm1;
    nm1 = n - imf3d_pkg::SIZE_W'(1);
    return (c == '0) ? nm1[imf3d_pkg::EDGE_W-1:0] : c - imf3d_pkg::EDGE_W'(1);
  endfunction

  function automatic imf3d_pkg::coord_t inc_wrap(imf3d_pkg::coord_t c, imf3d_pkg::size_t n);
    imf3d_pkg::size_t cp1;
    cp1 = imf3d_pkg::SIZE_W'(c) + imf3d_pkg::SIZE_W'(1);
    return (cp1 == n) ? '0 : cp1[imf3d_pkg::EDGE_W-1:0];
  endfunction

  assign req_fire  = req.valid && req.ready;
  assign req.ready = ctl_i.take && !clr_i.busy;
  assign out_full  = res_valid_q && !res.ready;
  assign commit_go = ctl_i.commit && !out_full;

  assign in_range = (imf3d_pkg::SIZE_W'(x_q) < cfg_i.nx) &&
                    (imf3d_pkg::SIZE_W'(y_q) < cfg_i.ny) &&
                    (imf3d_pkg::SIZE_W'(z_q) < cfg_i.nz);

  assign stat_o.req_fire = req_fire;
  assign stat_o.oor      = !in_range;
  assign stat_o.out_full = out_full;

  assign xm = dec_wrap(x_q, cfg_i.nx);
  assign xp = inc_wrap(x_q, cfg_i.nx);
  assign ym = dec_wrap(y_q, cfg_i.ny);
  assign yp = inc_wrap(y_q, cfg_i.ny);
  assign zm = dec_wrap(z_q, cfg_i.nz);
  assign zp = inc_wrap(z_q, cfg_i.nz);

  always_comb begin
    rd_o.en = ctl_i.rd_en;
    case (ctl_i.rd_sel)
      imf3d_pkg::RD_YM: rd_o.addr = {z_q, ym};
      imf3d_pkg::RD_YP: rd_o.addr = {z_q, yp};
      imf3d_pkg::RD_ZM: rd_o.addr = {zm, y_q};
      imf3d_pkg::RD_ZP: rd_o.addr = {zp, y_q};
      default:          rd_o.addr = {z_q, y_q};
    endcase
  end

  always_comb begin
    cur  = row_q[x_q];
    n_up = 3'(row_q[xm]) + 3'(row_q[xp]) + 3'(ym_q) + 3'(yp_q) + 3'(zm_q) + 3'(zp_q);
    nsum = $signed({n_up, 1'b0} - imf3d_pkg::NSUM_W'(6));
    thr  = cfg_i.thr[{cur, n_up}];
    flip = (cmd_q == imf3d_pkg::CMD_TRIAL) && (rnd_q <= thr);
    new_spin = (cmd_q == imf3d_pkg::CMD_TRIAL) ? (cur ^ flip) : sin_q;
    wr_row = row_q;
    wr_row[x_q] = new_spin;
    up_total_d = up_total_q;
    if (new_spin && !cur) begin
      up_total_d = up_total_q + imf3d_pkg::CNT_W'(1);
    end else if (!new_spin && cur) begin
      up_total_d = up_total_q - imf3d_pkg::CNT_W'(1);
    end
  end

  assign wr_o.en   = commit_go && in_range;
  assign wr_o.addr = {z_q, y_q};
  assign wr_o.data = wr_row;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= req.command;
      x_q   <= req.site_x;
      y_q   <= req.site_y;
      z_q   <= req.site_z;
      sin_q <= req.spin_in;
      rnd_q <= req.random_value;
    end
    case (ctl_i.cap)
      imf3d_pkg::CAP_ROW: row_q <= rd_data_i;
      imf3d_pkg::CAP_YM:  ym_q  <= rd_data_i[x_q];
      imf3d_pkg::CAP_YP:  yp_q  <= rd_data_i[x_q];
      imf3d_pkg::CAP_ZM:  zm_q  <= rd_data_i[x_q];
      imf3d_pkg::CAP_ZP:  zp_q  <= rd_data_i[x_q];
      default: ;
    endcase
    if (commit_go) begin
      res_flipped_q <= in_range && flip;
      res_spin_q    <= in_range && new_spin;
      res_nsum_q    <= in_range ? nsum : '0;
      res_up_q      <= in_range ? up_total_d : up_total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_total_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (clr_i.start) begin
        up_total_q <= '0;
      end else if (commit_go && in_range) begin
        up_total_q <= up_total_d;
      end
      if (commit_go) begin
        res_valid_q <= 1'b1;
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid         = res_valid_q;
  assign res.flipped       = res_flipped_q;
  assign res.spin_out      = res_spin_q;
  assign res.neighbour_sum = res_nsum_q;
  assign res.up_count      = res_up_q;

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_up_q == up_total_q)
    else $error("pending result count differs from lattice count");

  a_no_commit_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go |-> !clr_i.busy)
    else $error("write-back during clearing pass");
`endif

endmodule

`default_nettype wire

@@ sv/ising_metropolis_flip_3d_top.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_flip_3d_top
// 3D periodic Ising lattice with Metropolis single-spin trials.
// ----------------------------------------------------------------------------
// Each request writes one spin or runs one Metropolis trial and returns one
// result with the running up-spin count. A request in range passes through
// the eight steps of the control program before the next request is taken:
// an idle step that takes the request, five row reads of the lattice
// memory, which has one read port (site row, then the y and z neighbour
// rows), one capture step and the write-back. A request outside the extent
// in use goes from the site row read straight to the write-back step. A
// result that is not taken holds the program in the write-back step. After
// reset and after any write to a size register the lattice is cleared one
// row per cycle; while it is cleared no request is accepted; configuration
// writes are still taken.
`default_nettype none

module ising_metropolis_flip_3d_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [imf3d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [imf3d_pkg::CFG_W-1:0]     cfg_data_i,
  imf3d_req_if.sink                            req,
  imf3d_res_if.source                          res
);

  imf3d_pkg::size_t                  size_x_q, size_y_q, size_z_q;
  logic [imf3d_pkg::CFG_W-1:0]       tab_q [imf3d_pkg::TAB_REGS];
  logic                              clr_busy_q;
  imf3d_pkg::raddr_t                 clr_cnt_q;
  logic                              size_wr;

  imf3d_pkg::cfg_t    cfg;
  imf3d_pkg::clr_t    clr;
  imf3d_pkg::ctl_t    ctl;
  imf3d_pkg::stat_t   stat;
  imf3d_pkg::ram_rd_t rd;
  imf3d_pkg::ram_wr_t dp_wr, ram_wr;
  imf3d_pkg::row_t    rd_data;

  assign size_wr = cfg_we_i && ((cfg_idx_i == imf3d_pkg::CFG_SIZE_X) ||
                                (cfg_idx_i == imf3d_pkg::CFG_SIZE_Y) ||
                                (cfg_idx_i == imf3d_pkg::CFG_SIZE_Z));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= imf3d_pkg::SIZE_W'(32);
      size_y_q <= imf3d_pkg::SIZE_W'(32);
      size_z_q <= imf3d_pkg::SIZE_W'(32);
      for (int k = 0; k < imf3d_pkg::TAB_REGS; k++) begin
        tab_q[k] <= '1;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imf3d_pkg::CFG_SIZE_X:  size_x_q <= cfg_data_i[imf3d_pkg::SIZE_W-1:0];
        imf3d_pkg::CFG_SIZE_Y:  size_y_q <= cfg_data_i[imf3d_pkg::SIZE_W-1:0];
        imf3d_pkg::CFG_SIZE_Z:  size_z_q <= cfg_data_i[imf3d_pkg::SIZE_W-1:0];
        imf3d_pkg::CFG_TABLE_0: tab_q[0] <= cfg_data_i;
        imf3d_pkg::CFG_TABLE_1: tab_q[1] <= cfg_data_i;
        imf3d_pkg::CFG_TABLE_2: tab_q[2] <= cfg_data_i;
        imf3d_pkg::CFG_TABLE_3: tab_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.nx = imf3d_pkg::eff_size(size_x_q);
    cfg.ny = imf3d_pkg::eff_size(size_y_q);
    cfg.nz = imf3d_pkg::eff_size(size_z_q);
    for (int k = 0; k < imf3d_pkg::TAB_ENTRIES; k++) begin
      cfg.thr[k] = tab_q[k / 4][(k % 4) * imf3d_pkg::THR_W +: imf3d_pkg::THR_W];
    end
  end

  // lattice clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (size_wr) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + imf3d_pkg::ROW_AW'(1);
      if (clr_cnt_q == imf3d_pkg::ROW_AW'(imf3d_pkg::ROWS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign clr.start = size_wr;
  assign clr.busy  = clr_busy_q;

  always_comb begin
    ram_wr = dp_wr;
    if (clr_busy_q) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_cnt_q;
      ram_wr.data = '0;
    end
  end

  imf3d_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  imf3d_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .cfg_i     (cfg),
    .clr_i     (clr),
    .rd_data_i (rd_data),
    .stat_o    (stat),
    .rd_o      (rd),
    .wr_o      (dp_wr),
    .req       (req),
    .res       (res)
  );

  imf3d_ram u_ram (
    .clk_i     (clk_i),
    .rd_i      (rd),
    .wr_i      (ram_wr),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire
